// File: hdl/vector3_normalize_core_macros.svh
// Assertion macros for the vector normalization core.
`ifndef VECTOR3_NORMALIZE_CORE_MACROS_SVH
`define VECTOR3_NORMALIZE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define VEC3N_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector3_normalize_core: check failed");
`define VEC3N_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector3_normalize_core: check failed");
`else
`define VEC3N_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define VEC3N_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/vnorm_pkg.sv
// Shared constants for the vector normalization core.
package vnorm_pkg;

    localparam int COMPONENT_WIDTH_DEF    = 16;
    localparam int UNIT_FRACTION_BITS_DEF = 14;
    localparam int LEN_FRAC_BITS          = 8;
    localparam int LENGTH_WIDTH           = 24;
    localparam int UNIT_WIDTH             = 16;
    localparam int UNIT_POS_MAX           = 32767;
    localparam int UNIT_NEG_MAX           = 32768;
    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;

endpackage

// File: hdl/vector3_normalize_core.sv
// Pipelined 3D vector normalization: length in Q16.8 and unit vector in Q1.14.
//
// Input channel s_valid/s_ready carries one vector (s_vec_x, s_vec_y, s_vec_z),
// signed components. Result channel m_valid/m_ready carries the unit components
// m_unit_x/y/z (signed, UNIT_FRACTION_BITS fraction bits, truncated toward zero),
// m_length (floor of the exact root, 8 fraction bits, saturated to 24 bits) and
// m_zero_vector, set for an all-zero input with all other fields zero.
// Throughput: one transaction per cycle while the result channel is not stalled.
// The stages are one squaring stage, one sum stage, one root digit per stage
// (COMPONENT_WIDTH + 8 stages) and one quotient bit per stage for all three
// components (UNIT_FRACTION_BITS + 1 stages), then the output register.
// Reset (aresetn low, synchronous) clears every stage valid bit; in-flight
// transactions are dropped. When the receiver stalls with a result waiting, the
// whole pipeline holds and s_ready falls; empty output register lets it advance.
`include "vector3_normalize_core_macros.svh"
module vector3_normalize_core
    import vnorm_pkg::*;
#(
    parameter int COMPONENT_WIDTH    = COMPONENT_WIDTH_DEF,
    parameter int UNIT_FRACTION_BITS = UNIT_FRACTION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] s_vec_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_vec_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_vec_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [UNIT_WIDTH-1:0]      m_unit_x,
    output logic signed [UNIT_WIDTH-1:0]      m_unit_y,
    output logic signed [UNIT_WIDTH-1:0]      m_unit_z,
    output logic [LENGTH_WIDTH-1:0]           m_length,
    output logic                              m_zero_vector
);

    localparam int CW        = COMPONENT_WIDTH;
    localparam int SW        = 2 * CW;
    localparam int SQW       = 2 * CW - 1;
    localparam int RW        = CW + LEN_FRAC_BITS;
    localparam int RMW       = RW + 1;
    localparam int QW        = UNIT_FRACTION_BITS + 1;
    localparam int PRE_SHIFT = UNIT_FRACTION_BITS + LEN_FRAC_BITS - QW;
    localparam int QXW       = (QW > UNIT_WIDTH + 1) ? QW : UNIT_WIDTH + 1;
    localparam int LXW       = (RW > LENGTH_WIDTH) ? RW : LENGTH_WIDTH;

    logic pipe_en;

    logic signed [CW-1:0] comp_in [0:2];

    logic             p1_vld_reg;
    logic [SQW-1:0]   p1_sq_reg  [0:2];
    logic [CW-1:0]    p1_mag_reg [0:2];
    logic             p1_neg_reg [0:2];

    logic             sq_vld_reg  [0:RW];
    logic [SW-1:0]    sq_s_reg    [0:CW-1];
    logic [RMW-1:0]   sq_rem_reg  [0:RW-1];
    logic [RW-1:0]    sq_root_reg [0:RW];
    logic [CW-1:0]    sq_mag_reg  [0:RW][0:2];
    logic             sq_neg_reg  [0:RW][0:2];

    logic             dv_vld_reg [1:QW];
    logic [RW-1:0]    dv_len_reg [1:QW];
    logic [RW-1:0]    dv_rem_reg [1:QW-1][0:2];
    logic [QW-1:0]    dv_q_reg   [1:QW][0:2];
    logic             dv_neg_reg [1:QW][0:2];

    logic                  m_valid_reg;
    logic [UNIT_WIDTH-1:0] m_unit_reg [0:2];
    logic [UNIT_WIDTH-1:0] unit_next  [0:2];
    logic [LENGTH_WIDTH-1:0] m_length_reg;
    logic [LENGTH_WIDTH-1:0] length_next;
    logic                  m_zero_reg;
    logic                  zero_next;
    logic [LXW-1:0]        len_ext;

    assign pipe_en    = !m_valid_reg || m_ready;
    assign s_ready    = pipe_en;
    assign comp_in[0] = s_vec_x;
    assign comp_in[1] = s_vec_y;
    assign comp_in[2] = s_vec_z;

    // square and magnitude
    for (genvar c = 0; c < 3; c++) begin : g_square
        logic signed [SW-1:0] prod;
        logic                 neg;
        logic [CW-1:0]        mag;

        assign prod = comp_in[c] * comp_in[c];
        assign neg  = comp_in[c][CW-1];
        assign mag  = neg ? (~comp_in[c] + 1'b1) : comp_in[c];

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                p1_sq_reg[c]  <= prod[SQW-1:0];
                p1_mag_reg[c] <= mag;
                p1_neg_reg[c] <= neg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            p1_vld_reg <= s_valid;
        end
    end

    // sum of squares, root seed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (pipe_en) begin
            sq_vld_reg[0] <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sq_s_reg[0]    <= SW'(p1_sq_reg[0]) + SW'(p1_sq_reg[1]) + SW'(p1_sq_reg[2]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_seed
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                sq_mag_reg[0][c] <= p1_mag_reg[c];
                sq_neg_reg[0][c] <= p1_neg_reg[c];
            end
        end
    end

    // square root, one digit per stage
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int I = RW - 1 - k;
        logic [1:0]    pair;
        logic [RW+2:0] rem_sh;
        logic [RW+2:0] trial;
        logic          ge;

        if (I >= LEN_FRAC_BITS) begin : g_pair
            assign pair = sq_s_reg[k][2*(I-LEN_FRAC_BITS)+1 -: 2];
        end else begin : g_nopair
            assign pair = 2'b00;
        end

        assign rem_sh = {sq_rem_reg[k], pair};
        assign trial  = (RW+3)'({sq_root_reg[k], 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k+1] <= 1'b0;
            end else if (pipe_en) begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                sq_root_reg[k+1] <= {sq_root_reg[k][RW-2:0], ge};
            end
        end

        if (k + 1 < RW) begin : g_rem
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    sq_rem_reg[k+1] <= ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
                end
            end
        end

        if (k + 1 < CW) begin : g_sum
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    sq_s_reg[k+1] <= sq_s_reg[k];
                end
            end
        end

        for (genvar c = 0; c < 3; c++) begin : g_carry
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    sq_mag_reg[k+1][c] <= sq_mag_reg[k][c];
                    sq_neg_reg[k+1][c] <= sq_neg_reg[k][c];
                end
            end
        end
    end

    // division, one quotient bit per stage for all three components
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic          vld_in;
        logic [RW-1:0] len_in;

        if (j == 0) begin : g_first
            assign vld_in = sq_vld_reg[RW];
            assign len_in = sq_root_reg[RW];
        end else begin : g_next
            assign vld_in = dv_vld_reg[j];
            assign len_in = dv_len_reg[j];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j+1] <= 1'b0;
            end else if (pipe_en) begin
                dv_vld_reg[j+1] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                dv_len_reg[j+1] <= len_in;
            end
        end

        for (genvar c = 0; c < 3; c++) begin : g_lane
            logic [RW-1:0] rem_in;
            logic [QW-1:0] q_in;
            logic          neg_in;
            logic [RW:0]   rem_sh;
            logic          ge;

            if (j == 0) begin : g_first
                assign rem_in = RW'(sq_mag_reg[RW][c]) << PRE_SHIFT;
                assign q_in   = '0;
                assign neg_in = sq_neg_reg[RW][c];
            end else begin : g_next
                assign rem_in = dv_rem_reg[j][c];
                assign q_in   = dv_q_reg[j][c];
                assign neg_in = dv_neg_reg[j][c];
            end

            assign rem_sh = {rem_in, 1'b0};
            assign ge     = rem_sh >= {1'b0, len_in};

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    dv_q_reg[j+1][c]   <= {q_in[QW-2:0], ge};
                    dv_neg_reg[j+1][c] <= neg_in;
                end
            end

            if (j + 1 < QW) begin : g_rem
                always_ff @(posedge aclk) begin
                    if (pipe_en) begin
                        dv_rem_reg[j+1][c] <= ge ? RW'(rem_sh - {1'b0, len_in})
                                                 : RW'(rem_sh);
                    end
                end
            end
        end
    end

    // saturate, sign and register the result
    assign zero_next   = dv_len_reg[QW] == '0;
    assign len_ext     = LXW'(dv_len_reg[QW]);
    assign length_next = (len_ext > LXW'(LENGTH_MAX)) ? LENGTH_MAX
                                                      : LENGTH_WIDTH'(len_ext);

    for (genvar c = 0; c < 3; c++) begin : g_unit
        logic [QXW-1:0] q_ext;
        logic [QXW-1:0] clamp;

        assign q_ext = QXW'(dv_q_reg[QW][c]);

        always_comb begin
            if (dv_neg_reg[QW][c]) begin
                clamp = (q_ext > QXW'(UNIT_NEG_MAX)) ? QXW'(UNIT_NEG_MAX) : q_ext;
            end else begin
                clamp = (q_ext > QXW'(UNIT_POS_MAX)) ? QXW'(UNIT_POS_MAX) : q_ext;
            end
            if (zero_next) begin
                unit_next[c] = '0;
            end else if (dv_neg_reg[QW][c]) begin
                unit_next[c] = UNIT_WIDTH'(QXW'(0) - clamp);
            end else begin
                unit_next[c] = UNIT_WIDTH'(clamp);
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                m_unit_reg[c] <= unit_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= dv_vld_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_length_reg <= zero_next ? '0 : length_next;
            m_zero_reg   <= zero_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_unit_x      = m_unit_reg[0];
    assign m_unit_y      = m_unit_reg[1];
    assign m_unit_z      = m_unit_reg[2];
    assign m_length      = m_length_reg;
    assign m_zero_vector = m_zero_reg;

    `VEC3N_ASSERT_IMPL(a_zero_clears_fields, aclk, aresetn, m_valid && m_zero_vector, m_unit_x == '0 && m_unit_y == '0 && m_unit_z == '0 && m_length == '0)
    `VEC3N_ASSERT_IMPL(a_nonzero_has_length, aclk, aresetn, m_valid && !m_zero_vector, m_length != '0)
    `VEC3N_ASSERT_NEXT(a_stall_freezes_pipe, aclk, aresetn, !s_ready, $stable(dv_vld_reg[QW]) && $stable(p1_vld_reg))

endmodule
